// ----- hw/rtl/pxz_pkg.sv -----
// Shared constants for the polynomial extrapolation block.
// No dependencies.
package pxz_pkg;

    // Number of variables handled per sample point (fixed by the port set)
    localparam int LANES = 4;
    localparam int LANE_W = 2;

    // Default depth of the point store
    localparam int MAX_POINTS_DEFAULT = 8;

    // Reset value of the point count register
    localparam logic [3:0] POINT_COUNT_RESET = 4'd4;

    // Quotient bits produced by the divider
    localparam int DIV_BITS = 33;

endpackage

// ----- hw/rtl/polynomial_extrapolation_to_zero.sv -----
// Neville extrapolation to step zero over a set of sample points, four lanes.
// Depends on pxz_pkg.

// A set of point_count points is written one transaction at a time; each point
// is stored in steps (accept, one tableau write per lane, one step write).
// The last point of a set then runs the c/d tableau out of two synchronous
// memories, each with one read and one write port, with one shared radix-2
// divider: for each of the n(n-1)/2 tableau cells the step pair is fetched,
// then each lane in turn goes through operand fetch, division, two
// multiplies and write-back, and the result register is loaded at the end. A
// faulty set (zero or non-decreasing step) skips the tableau and yields
// zeros with order_fault set. A result still waiting on m_ready holds the
// block in its final step, so no new point is accepted until it is taken.
module polynomial_extrapolation_to_zero
    import pxz_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [3:0]         cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [31:0]        s_step_value,
    input  logic signed [31:0] s_sample_lane0,
    input  logic signed [31:0] s_sample_lane1,
    input  logic signed [31:0] s_sample_lane2,
    input  logic signed [31:0] s_sample_lane3,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_estimate_lane0,
    output logic signed [31:0] m_estimate_lane1,
    output logic signed [31:0] m_estimate_lane2,
    output logic signed [31:0] m_estimate_lane3,
    output logic signed [31:0] m_error_lane0,
    output logic signed [31:0] m_error_lane1,
    output logic signed [31:0] m_error_lane2,
    output logic signed [31:0] m_error_lane3,
    output logic               m_order_fault
);

    localparam int CW        = $clog2(MAX_POINTS + 1);
    localparam int STEP_BASE = MAX_POINTS * LANES;
    localparam int DEPTH     = STEP_BASE + MAX_POINTS;
    localparam int AW        = $clog2(DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_LOAD_STEP, ST_RD_HO, ST_RD_HP, ST_CAP_HP, ST_RD_CD,
        ST_CALC, ST_DIV_INIT, ST_DIV, ST_FAC, ST_MUL_D, ST_MUL_C, ST_WR_C, ST_DONE
    } state_t;

    state_t             state_reg;
    logic [3:0]         point_count_reg;
    logic [CW-1:0]      points_received_reg;
    logic               fault_reg;
    logic [31:0]        last_step_reg;
    logic [CW-1:0]      pos_reg;
    logic [31:0]        step_reg;
    logic signed [31:0] sample_reg [LANES];
    logic signed [31:0] est_reg [LANES];
    logic signed [31:0] err_reg [LANES];
    logic [CW-1:0]      m_reg;
    logic [CW-1:0]      i_reg;
    logic [LANE_W-1:0]  k_reg;
    logic [31:0]        ho_reg;
    logic [31:0]        hp_reg;
    logic [31:0]        den_reg;
    logic               neg_reg;
    logic [32:0]        mag_reg;
    logic [32:0]        rem_reg;
    logic [32:0]        quo_reg;
    logic [5:0]         cnt_reg;
    logic               dsat_reg;
    logic [31:0]        fmag_reg;
    logic [63:0]        prod_reg;

    logic               m_valid_reg;
    logic signed [31:0] out_est_reg [LANES];
    logic signed [31:0] out_err_reg [LANES];
    logic               out_fault_reg;

    // Tableau memories; steps live above the d entries in the lower one
    logic [31:0] upper_mem [DEPTH];
    logic [31:0] lower_mem [DEPTH];
    logic          upper_we, lower_we;
    logic [AW-1:0] upper_waddr, lower_waddr, upper_raddr, lower_raddr;
    logic [31:0]   upper_wdata, lower_wdata;
    logic [31:0]   upper_rdata, lower_rdata;

    logic signed [31:0] sample_in [LANES];
    logic [CW-1:0]      active_n;
    logic               fault_now;
    logic               last_point;
    logic               col_last;
    logic signed [32:0] w_val;
    logic [32:0]        rem_sh;
    logic [32:0]        rem_sub;
    logic               q_bit;
    logic signed [31:0] d_sat;
    logic signed [31:0] c_sat;
    logic signed [32:0] est_sum;
    logic signed [31:0] est_new;

    function automatic logic [AW-1:0] tab_addr(logic [CW-1:0] row, logic [LANE_W-1:0] lane);
        return AW'(row) * AW'(LANES) + AW'(lane);
    endfunction

    // Saturating (h * f) / 2^16 from the magnitude product and sign of f
    function automatic logic signed [31:0] sat_prod(logic [63:0] prod, logic neg);
        logic [31:0] low;
        low = {1'b0, prod[46:16]};
        if (|prod[63:47]) begin
            return neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return neg ? -$signed(low) : $signed(low);
    endfunction

    assign sample_in[0] = s_sample_lane0;
    assign sample_in[1] = s_sample_lane1;
    assign sample_in[2] = s_sample_lane2;
    assign sample_in[3] = s_sample_lane3;

    // Effective point count
    always_comb begin
        if (point_count_reg == 4'd0) begin
            active_n = CW'(1);
        end else if ({1'b0, point_count_reg} > 5'(MAX_POINTS)) begin
            active_n = CW'(MAX_POINTS);
        end else begin
            active_n = CW'(point_count_reg);
        end
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign fault_now  = (s_step_value == 32'd0) ||
                        ((points_received_reg != '0) && (s_step_value >= last_step_reg));
    assign last_point = ((pos_reg + CW'(1)) >= active_n);
    assign col_last   = (i_reg == (active_n - CW'(1) - m_reg));

    // Datapath helpers
    assign w_val   = $signed({upper_rdata[31], upper_rdata}) -
                     $signed({lower_rdata[31], lower_rdata});
    assign rem_sh  = {rem_reg[31:0], quo_reg[32]};
    assign q_bit   = (rem_sh >= {1'b0, den_reg});
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign d_sat   = sat_prod(prod_reg, neg_reg);
    assign c_sat   = d_sat;
    assign est_sum = $signed({est_reg[k_reg][31], est_reg[k_reg]}) +
                     $signed({d_sat[31], d_sat});
    always_comb begin
        if (est_sum > 33'sh0_7FFF_FFFF) begin
            est_new = 32'sh7FFF_FFFF;
        end else if (est_sum < -33'sh0_8000_0000) begin
            est_new = 32'sh8000_0000;
        end else begin
            est_new = est_sum[31:0];
        end
    end

    // Memory access control
    always_comb begin
        upper_we    = 1'b0;
        lower_we    = 1'b0;
        upper_waddr = tab_addr(i_reg, k_reg);
        lower_waddr = tab_addr(i_reg, k_reg);
        upper_wdata = c_sat;
        lower_wdata = d_sat;
        upper_raddr = tab_addr(i_reg + CW'(1), k_reg);
        lower_raddr = tab_addr(i_reg, k_reg);
        case (state_reg)
            ST_LOAD: begin
                upper_we    = 1'b1;
                lower_we    = 1'b1;
                upper_waddr = tab_addr(pos_reg, k_reg);
                lower_waddr = tab_addr(pos_reg, k_reg);
                upper_wdata = sample_reg[k_reg];
                lower_wdata = sample_reg[k_reg];
            end
            ST_LOAD_STEP: begin
                lower_we    = 1'b1;
                lower_waddr = AW'(STEP_BASE) + AW'(pos_reg);
                lower_wdata = step_reg;
            end
            ST_RD_HO: lower_raddr = AW'(STEP_BASE) + AW'(i_reg);
            ST_RD_HP: lower_raddr = AW'(STEP_BASE) + AW'(i_reg + m_reg);
            ST_MUL_C: lower_we = 1'b1;
            ST_WR_C:  upper_we = 1'b1;
            default: ;
        endcase
    end

    // Upper (c) tableau memory
    always_ff @(posedge aclk) begin
        if (upper_we) begin
            upper_mem[upper_waddr] <= upper_wdata;
        end
        upper_rdata <= upper_mem[upper_raddr];
    end

    // Lower (d) tableau and step memory
    always_ff @(posedge aclk) begin
        if (lower_we) begin
            lower_mem[lower_waddr] <= lower_wdata;
        end
        lower_rdata <= lower_mem[lower_raddr];
    end

    // Sequencer and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= ST_IDLE;
            point_count_reg     <= POINT_COUNT_RESET;
            points_received_reg <= '0;
            fault_reg           <= 1'b0;
            m_valid_reg         <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                point_count_reg     <= cfg_wr_data;
                points_received_reg <= '0;
                fault_reg           <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        step_reg      <= s_step_value;
                        last_step_reg <= s_step_value;
                        pos_reg       <= points_received_reg;
                        fault_reg     <= fault_reg | fault_now;
                        for (int j = 0; j < LANES; j++) sample_reg[j] <= sample_in[j];
                        k_reg     <= '0;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    k_reg <= k_reg + LANE_W'(1);
                    if (k_reg == LANE_W'(LANES - 1)) begin
                        state_reg <= ST_LOAD_STEP;
                    end
                end
                ST_LOAD_STEP: begin
                    points_received_reg <= pos_reg + CW'(1);
                    if (last_point) begin
                        for (int j = 0; j < LANES; j++) begin
                            est_reg[j] <= sample_reg[j];
                            err_reg[j] <= sample_reg[j];
                        end
                        m_reg <= CW'(1);
                        i_reg <= '0;
                        k_reg <= '0;
                        state_reg <= (fault_reg || active_n == CW'(1)) ? ST_DONE : ST_RD_HO;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_RD_HO: state_reg <= ST_RD_HP;
                ST_RD_HP: begin
                    ho_reg    <= lower_rdata;
                    state_reg <= ST_CAP_HP;
                end
                ST_CAP_HP: begin
                    hp_reg    <= lower_rdata;
                    den_reg   <= ho_reg - lower_rdata;
                    state_reg <= ST_RD_CD;
                end
                ST_RD_CD: state_reg <= ST_CALC;
                // w = c[i+1] - d[i], kept as sign and magnitude
                ST_CALC: begin
                    neg_reg   <= w_val[32];
                    mag_reg   <= w_val[32] ? 33'(-w_val) : 33'(w_val);
                    state_reg <= ST_DIV_INIT;
                end
                ST_DIV_INIT: begin
                    dsat_reg  <= ({17'd0, mag_reg} >= {1'b0, den_reg, 17'd0});
                    rem_reg   <= {17'd0, mag_reg[32:17]};
                    quo_reg   <= {mag_reg[16:0], 16'd0};
                    cnt_reg   <= 6'(DIV_BITS);
                    state_reg <= ST_DIV;
                end
                // Restoring division, one quotient bit a cycle
                ST_DIV: begin
                    rem_reg <= q_bit ? rem_sub : rem_sh;
                    quo_reg <= {quo_reg[31:0], q_bit};
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1) begin
                        state_reg <= ST_FAC;
                    end
                end
                // Saturate the factor magnitude
                ST_FAC: begin
                    if (neg_reg) begin
                        fmag_reg <= (dsat_reg || quo_reg[32] || (quo_reg[31] && |quo_reg[30:0]))
                                    ? 32'h8000_0000 : quo_reg[31:0];
                    end else begin
                        fmag_reg <= (dsat_reg || quo_reg[32] || quo_reg[31])
                                    ? 32'h7FFF_FFFF : quo_reg[31:0];
                    end
                    state_reg <= ST_MUL_D;
                end
                ST_MUL_D: begin
                    prod_reg  <= 64'(hp_reg) * 64'(fmag_reg);
                    state_reg <= ST_MUL_C;
                end
                // d written this cycle; fold it into the estimate at column end
                ST_MUL_C: begin
                    if (col_last) begin
                        est_reg[k_reg] <= est_new;
                        if (m_reg == active_n - CW'(1)) begin
                            err_reg[k_reg] <= d_sat;
                        end
                    end
                    prod_reg  <= 64'(ho_reg) * 64'(fmag_reg);
                    state_reg <= ST_WR_C;
                end
                ST_WR_C: begin
                    k_reg <= k_reg + LANE_W'(1);
                    if (k_reg != LANE_W'(LANES - 1)) begin
                        state_reg <= ST_RD_CD;
                    end else if (!col_last) begin
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= ST_RD_HO;
                    end else if (m_reg == active_n - CW'(1)) begin
                        state_reg <= ST_DONE;
                    end else begin
                        m_reg     <= m_reg + CW'(1);
                        i_reg     <= '0;
                        state_reg <= ST_RD_HO;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        for (int j = 0; j < LANES; j++) begin
                            out_est_reg[j] <= fault_reg ? 32'sd0 : est_reg[j];
                            out_err_reg[j] <= fault_reg ? 32'sd0 : err_reg[j];
                        end
                        out_fault_reg       <= fault_reg;
                        m_valid_reg         <= 1'b1;
                        points_received_reg <= '0;
                        fault_reg           <= 1'b0;
                        state_reg           <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_estimate_lane0 = out_est_reg[0];
    assign m_estimate_lane1 = out_est_reg[1];
    assign m_estimate_lane2 = out_est_reg[2];
    assign m_estimate_lane3 = out_est_reg[3];
    assign m_error_lane0    = out_err_reg[0];
    assign m_error_lane1    = out_err_reg[1];
    assign m_error_lane2    = out_err_reg[2];
    assign m_error_lane3    = out_err_reg[3];
    assign m_order_fault    = out_fault_reg;

endmodule
